[src/fbpb_pkg.sv]
// Package of the framebuffer pixel blitter: register map, configuration and
// result types, depth codes and the RGB565 packing function. No dependencies.
package fbpb_pkg;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned PixelWidth   = 32;
   localparam int unsigned AddrWidth    = 32;
   localparam int unsigned BytesWidth   = 3;
   localparam int unsigned TotalWidth   = 27;
   localparam int unsigned ReqDataWidth = 32;
   localparam int unsigned RspDataWidth = 96;

   typedef enum logic [2:0] {
      REG_FB_BASE      = 3'd0,
      REG_ROW_PITCH    = 3'd1,
      REG_X_OFFSET     = 3'd2,
      REG_Y_OFFSET     = 3'd3,
      REG_FRAME_WIDTH  = 3'd4,
      REG_FRAME_HEIGHT = 3'd5,
      REG_DEPTH_SELECT = 3'd6,
      REG_SRC_IS_DST   = 3'd7
   } fbpb_reg_type;

   localparam logic [1:0] DEPTH_RGB565 = 2'd0;
   localparam logic [1:0] DEPTH_COPY   = 2'd1;

   localparam logic [BytesWidth-1:0] BYTES_RGB565 = 3'd2;
   localparam logic [BytesWidth-1:0] BYTES_COPY   = 3'd4;

   typedef struct packed {
      logic [31:0] fb_base;
      logic [15:0] row_pitch;
      logic [11:0] x_offset;
      logic [11:0] y_offset;
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [1:0]  depth_select;
      logic        src_is_dst;
   } fbpb_cfg_type;

   typedef struct packed {
      logic                  write_enable;
      logic [AddrWidth-1:0]  write_address;
      logic [PixelWidth-1:0] write_data;
      logic [BytesWidth-1:0] write_bytes;
      logic                  frame_last;
      logic [TotalWidth-1:0] frame_bytes;
   } fbpb_result_type;

   function automatic logic [15:0] to_rgb565(input logic [PixelWidth-1:0] pixel);
      return {pixel[23:19], pixel[15:10], pixel[7:3]};
   endfunction

endpackage

[src/fbpb_csr.sv]
// Configuration register file of the framebuffer pixel blitter, reached over
// an APB-style port. Depends on fbpb_pkg.
module fbpb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fbpb_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [fbpb_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [fbpb_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                csr_pready,
   output fbpb_pkg::fbpb_cfg_type              cfg
);
   import fbpb_pkg::*;

   localparam fbpb_cfg_type CfgReset = '{
      fb_base:      32'd0,
      row_pitch:    16'd0,
      x_offset:     12'd0,
      y_offset:     12'd0,
      frame_width:  13'd1,
      frame_height: 13'd1,
      depth_select: DEPTH_COPY,
      src_is_dst:   1'b0
   };

   fbpb_cfg_type cfg_ff;
   fbpb_cfg_type cfg_in;
   fbpb_reg_type reg_index;
   logic         write_strobe;

   assign reg_index    = fbpb_reg_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign write_strobe = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready   = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         unique case (reg_index)
            REG_FB_BASE:      cfg_in.fb_base      = csr_pwdata;
            REG_ROW_PITCH:    cfg_in.row_pitch    = csr_pwdata[15:0];
            REG_X_OFFSET:     cfg_in.x_offset     = csr_pwdata[11:0];
            REG_Y_OFFSET:     cfg_in.y_offset     = csr_pwdata[11:0];
            REG_FRAME_WIDTH:  cfg_in.frame_width  = csr_pwdata[12:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height = csr_pwdata[12:0];
            REG_DEPTH_SELECT: cfg_in.depth_select = csr_pwdata[1:0];
            REG_SRC_IS_DST:   cfg_in.src_is_dst   = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_FB_BASE:      csr_prdata = cfg_ff.fb_base;
         REG_ROW_PITCH:    csr_prdata = CsrDataWidth'(cfg_ff.row_pitch);
         REG_X_OFFSET:     csr_prdata = CsrDataWidth'(cfg_ff.x_offset);
         REG_Y_OFFSET:     csr_prdata = CsrDataWidth'(cfg_ff.y_offset);
         REG_FRAME_WIDTH:  csr_prdata = CsrDataWidth'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: csr_prdata = CsrDataWidth'(cfg_ff.frame_height);
         REG_DEPTH_SELECT: csr_prdata = CsrDataWidth'(cfg_ff.depth_select);
         REG_SRC_IS_DST:   csr_prdata = CsrDataWidth'(cfg_ff.src_is_dst);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/fbpb_pixel_path.sv]
// Per-pixel datapath of the framebuffer pixel blitter: raster counters, row
// address, destination address, colour conversion and frame total. Depends on fbpb_pkg.
module fbpb_pixel_path #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  fbpb_pkg::fbpb_cfg_type               cfg,
   input  logic [fbpb_pkg::PixelWidth-1:0]      pixel,
   output fbpb_pkg::fbpb_result_type            result
);
   import fbpb_pkg::*;

   localparam int unsigned ColWidth  = $clog2(MAX_WIDTH);
   localparam int unsigned RowWidth  = $clog2(MAX_HEIGHT);
   localparam int unsigned WideWidth = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HighWidth = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned XSumWidth = ((ColWidth > 12) ? ColWidth : 12) + 1;
   localparam int unsigned YSumWidth = ((RowWidth > 12) ? RowWidth : 12) + 1;
   localparam int unsigned AreaWidth = WideWidth + HighWidth;
   localparam int unsigned FullWidth = AreaWidth + 2;

   logic [ColWidth-1:0]    column_count_ff, column_count_in;
   logic [RowWidth-1:0]    row_count_ff, row_count_in;
   logic [AddrWidth-1:0]   row_address_ff, row_address_in;

   logic [WideWidth-1:0]   width_clamped;
   logic [HighWidth-1:0]   height_clamped;
   logic                   supported;
   logic                   write_on;
   logic                   half_depth;
   logic                   end_row;
   logic                   last;
   logic [YSumWidth-1:0]   y_sum;
   logic [XSumWidth-1:0]   x_sum;
   logic [YSumWidth+15:0]  row_product;
   logic [AddrWidth-1:0]   column_term;
   logic [AreaWidth-1:0]   area;
   logic [FullWidth-1:0]   area_bytes;

   always_comb begin
      if (cfg.frame_width == '0) begin
         width_clamped = WideWidth'(1);
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         width_clamped = WideWidth'(MAX_WIDTH);
      end else begin
         width_clamped = WideWidth'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         height_clamped = HighWidth'(1);
      end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
         height_clamped = HighWidth'(MAX_HEIGHT);
      end else begin
         height_clamped = HighWidth'(cfg.frame_height);
      end
   end

   assign supported  = (cfg.fb_base != '0) && (cfg.depth_select <= DEPTH_COPY);
   assign half_depth = (cfg.depth_select == DEPTH_RGB565);
   assign write_on   = supported && !((cfg.depth_select == DEPTH_COPY) && cfg.src_is_dst);
   assign end_row    = (32'(column_count_ff) + 32'd1) >= 32'(width_clamped);
   assign last       = end_row && ((32'(row_count_ff) + 32'd1) >= 32'(height_clamped));

   assign y_sum       = YSumWidth'(cfg.y_offset) + YSumWidth'(row_count_ff);
   assign x_sum       = XSumWidth'(cfg.x_offset) + XSumWidth'(column_count_ff);
   assign row_product = y_sum * cfg.row_pitch;
   assign column_term = half_depth ? (AddrWidth'(x_sum) << 1) : (AddrWidth'(x_sum) << 2);
   assign area        = width_clamped * height_clamped;
   assign area_bytes  = half_depth ? (FullWidth'(area) << 1) : (FullWidth'(area) << 2);

   assign row_address_in = (column_count_ff == '0)
                           ? cfg.fb_base + AddrWidth'(row_product) : row_address_ff;

   always_comb begin
      result               = '0;
      result.write_enable  = write_on;
      result.frame_last    = last;
      if (write_on) begin
         result.write_address = row_address_in + column_term;
         result.write_data    = half_depth ? PixelWidth'(to_rgb565(pixel)) : pixel;
         result.write_bytes   = half_depth ? BYTES_RGB565 : BYTES_COPY;
      end
      if (last && supported) begin
         result.frame_bytes = TotalWidth'(area_bytes);
      end
   end

   always_comb begin
      if (last) begin
         column_count_in = '0;
         row_count_in    = '0;
      end else if (end_row) begin
         column_count_in = '0;
         row_count_in    = row_count_ff + RowWidth'(1);
      end else begin
         column_count_in = column_count_ff + ColWidth'(1);
         row_count_in    = row_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         row_address_ff  <= '0;
      end else if (advance) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         row_address_ff  <= row_address_in;
      end
   end

endmodule

[src/framebuffer_pixel_blitter_core.sv]
// Framebuffer pixel blitter: turns XRGB8888 source pixels into framebuffer
// writes. Instantiates fbpb_csr and fbpb_pixel_path; depends on fbpb_pkg.
//
// Usage:
// Source pixels arrive on the req_ stream in raster order, one per transfer,
// the pixel in req_tdata[31:0]. Each pixel gives exactly one result transfer
// on the rsp_ stream: write address, write data, byte count and frame total in
// rsp_tdata, the write enable in rsp_tuser and the last-pixel flag in rsp_tlast.
// The user writes the registers over the csr_ port only while no pixel is in
// flight; the block does not enforce this. A pixel is held in an input
// register, the address, colour conversion and frame total are formed in one
// pass of logic, and the result is held in an output register, which takes it
// when empty or being read. One pixel is accepted every cycle while the
// receiver keeps rsp_tready high; the row address and frame area multipliers
// set the clock period.
// When the receiver stalls, the pending result holds and one more pixel may
// wait in the input register before req_tready falls.
// Reset clears both registers' valid flags, the raster counters and the row
// address, and loads the register defaults (one-by-one frame, 32-bit copy,
// writes disabled by a zero base).
module framebuffer_pixel_blitter_core #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: source_pixel [31:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [fbpb_pkg::ReqDataWidth-1:0]   req_tdata,
   // rsp_tdata: write_address [31:0], write_data [63:32], write_bytes [66:64],
   // frame_bytes [93:67], zero [95:94]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fbpb_pkg::RspDataWidth-1:0]   rsp_tdata,
   // rsp_tuser: write_enable [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fbpb_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [fbpb_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [fbpb_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import fbpb_pkg::*;

   fbpb_cfg_type          cfg;
   fbpb_result_type       result;
   fbpb_result_type       rsp_ff;
   logic [PixelWidth-1:0] pixel_ff;
   logic                  pixel_valid_ff;
   logic                  rsp_valid_ff;
   logic                  advance;

   assign advance    = pixel_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pixel_valid_ff || advance;

   fbpb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fbpb_pixel_path #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pixel_path (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .pixel   (pixel_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_tready) begin
            pixel_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pixel_ff <= req_tdata[PixelWidth-1:0];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.write_enable;
   assign rsp_tlast  = rsp_ff.frame_last;
   assign rsp_tdata  = {2'b00, rsp_ff.frame_bytes, rsp_ff.write_bytes,
                        rsp_ff.write_data, rsp_ff.write_address};

   a_empty_stage_accepts : assert property (@(posedge clock) disable iff (reset)
      !pixel_valid_ff |-> req_tready)
      else $error("input stage empty but pixel not accepted");

   a_no_bubble : assert property (@(posedge clock) disable iff (reset)
      (pixel_valid_ff && rsp_tready) |-> (advance && req_tready))
      else $error("pipeline stalled without back-pressure");

   a_idle_write_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.write_enable) |->
      (rsp_ff.write_address == '0 && rsp_ff.write_data == '0 && rsp_ff.write_bytes == '0))
      else $error("write fields set without a write");

   a_write_size : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.write_enable) |->
      (rsp_ff.write_bytes == BYTES_RGB565 || rsp_ff.write_bytes == BYTES_COPY))
      else $error("illegal write size");

   a_total_on_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.frame_last) |-> (rsp_ff.frame_bytes == '0))
      else $error("frame total reported before the last pixel");

endmodule

[bench/fbpb_blit_checker.sv]
// Result checker for the framebuffer pixel blitter: follows register writes and pixel
// transfers, predicts each framebuffer write and compares it with the result stream.
// Depends on fbpb_pkg for the register, depth and result types.
module fbpb_blit_checker #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [fbpb_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [fbpb_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic                              rsp_tuser,
   input  logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fbpb_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [fbpb_pkg::CsrDataWidth-1:0] csr_pwdata,
   input  logic                              csr_pready,
   output int unsigned                       fail_count,
   output int unsigned                       outstanding
);
   import fbpb_pkg::*;

   fbpb_cfg_type    shadow_cfg;
   logic [31:0]     column_pos;
   logic [31:0]     row_pos;
   logic [31:0]     line_base;
   fbpb_result_type expected_writes[$];
   int unsigned     mismatches = 0;

   function automatic logic [31:0] clamp_extent(input logic [12:0] size, input int unsigned hi);
      if (size == 13'd0) return 32'd1;
      if (size > hi) return hi;
      return {19'd0, size};
   endfunction

   function automatic fbpb_result_type predict_blit(input logic [31:0] pixel);
      fbpb_result_type res;
      logic [31:0]     span;
      logic [31:0]     rows;
      logic [31:0]     bpp;
      logic            enabled;
      logic            writes;
      logic            end_row;
      logic            last;
      span    = clamp_extent(shadow_cfg.frame_width, MAX_WIDTH);
      rows    = clamp_extent(shadow_cfg.frame_height, MAX_HEIGHT);
      enabled = (shadow_cfg.fb_base != 32'd0) &&
                (shadow_cfg.depth_select == DEPTH_RGB565 ||
                 shadow_cfg.depth_select == DEPTH_COPY);
      bpp     = (shadow_cfg.depth_select == DEPTH_RGB565) ? 32'(BYTES_RGB565) : 32'(BYTES_COPY);
      writes  = enabled && !(shadow_cfg.depth_select == DEPTH_COPY && shadow_cfg.src_is_dst);
      end_row = (column_pos + 32'd1 >= span);
      last    = end_row && (row_pos + 32'd1 >= rows);
      res     = '0;
      if (column_pos == 32'd0) begin
         line_base = shadow_cfg.fb_base +
                     (32'(shadow_cfg.y_offset) + row_pos) * 32'(shadow_cfg.row_pitch);
      end
      if (writes) begin
         res.write_enable  = 1'b1;
         res.write_address = line_base + (32'(shadow_cfg.x_offset) + column_pos) * bpp;
         res.write_data    = (shadow_cfg.depth_select == DEPTH_RGB565) ?
                             {16'd0, pixel[23:19], pixel[15:10], pixel[7:3]} : pixel;
         res.write_bytes   = bpp[BytesWidth-1:0];
      end
      res.frame_last = last;
      if (last && enabled) begin
         res.frame_bytes = TotalWidth'(span * rows * bpp);
      end
      if (last) begin
         column_pos = 32'd0;
         row_pos    = 32'd0;
      end else if (end_row) begin
         column_pos = 32'd0;
         row_pos    = row_pos + 32'd1;
      end else begin
         column_pos = column_pos + 32'd1;
      end
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      fbpb_result_type seen;
      fbpb_result_type wanted;
      if (reset) begin
         shadow_cfg              = '0;
         shadow_cfg.frame_width  = 13'd1;
         shadow_cfg.frame_height = 13'd1;
         shadow_cfg.depth_select = DEPTH_COPY;
         column_pos              = 32'd0;
         row_pos                 = 32'd0;
         line_base               = 32'd0;
         expected_writes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (fbpb_reg_type'(csr_paddr[4:2]))
               REG_FB_BASE:      shadow_cfg.fb_base      = csr_pwdata;
               REG_ROW_PITCH:    shadow_cfg.row_pitch    = csr_pwdata[15:0];
               REG_X_OFFSET:     shadow_cfg.x_offset     = csr_pwdata[11:0];
               REG_Y_OFFSET:     shadow_cfg.y_offset     = csr_pwdata[11:0];
               REG_FRAME_WIDTH:  shadow_cfg.frame_width  = csr_pwdata[12:0];
               REG_FRAME_HEIGHT: shadow_cfg.frame_height = csr_pwdata[12:0];
               REG_DEPTH_SELECT: shadow_cfg.depth_select = csr_pwdata[1:0];
               REG_SRC_IS_DST:   shadow_cfg.src_is_dst   = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_writes.push_back(predict_blit(req_tdata[31:0]));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.write_enable  = rsp_tuser;
            seen.write_address = rsp_tdata[31:0];
            seen.write_data    = rsp_tdata[63:32];
            seen.write_bytes   = rsp_tdata[66:64];
            seen.frame_bytes   = rsp_tdata[93:67];
            seen.frame_last    = rsp_tlast;
            if (expected_writes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: result transfer with no pixel outstanding, addr=%h data=%h",
                           $time, seen.write_address, seen.write_data);
               end
            end else begin
               wanted = expected_writes.pop_front();
               if (seen.write_enable !== wanted.write_enable ||
                   seen.write_address !== wanted.write_address ||
                   seen.write_data !== wanted.write_data ||
                   seen.write_bytes !== wanted.write_bytes ||
                   seen.frame_last !== wanted.frame_last ||
                   seen.frame_bytes !== wanted.frame_bytes ||
                   rsp_tdata[95:94] !== 2'b00) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"%0t: expected en=%0b addr=%h data=%h bytes=%0d last=%0b ",
                               "total=%0d, got en=%0b addr=%h data=%h bytes=%0d last=%0b ",
                               "total=%0d pad=%b"}, $time,
                              wanted.write_enable, wanted.write_address, wanted.write_data,
                              wanted.write_bytes, wanted.frame_last, wanted.frame_bytes,
                              seen.write_enable, seen.write_address, seen.write_data,
                              seen.write_bytes, seen.frame_last, seen.frame_bytes,
                              rsp_tdata[95:94]);
                  end
               end
            end
         end
      end
      fail_count  <= mismatches;
      outstanding <= expected_writes.size();
   end

endmodule

[bench/framebuffer_pixel_blitter_core_test.sv]
// Top of the framebuffer pixel blitter testbench: clock, reset, register set-up, pixel
// stimulus and receiver stalls, with fbpb_blit_checker beside the block giving the verdict.
// Depends on fbpb_pkg, framebuffer_pixel_blitter_core and fbpb_blit_checker.
module framebuffer_pixel_blitter_core_test;
   import fbpb_pkg::*;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b1;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;
   logic                    calm        = 1'b0;
   int unsigned             fail_count;
   int unsigned             outstanding;
   int unsigned             stall_left  = 0;

   always #4 clock = ~clock;

   framebuffer_pixel_blitter_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fbpb_blit_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // The receiver alternates between bursts of stalls and bursts of readiness.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_tready <= calm || ($urandom_range(0, 2) != 0);
      end else begin
         stall_left = stall_left - 1;
      end
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic push_pixel(input logic [31:0] pixel);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input fbpb_reg_type index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [31:0] pick_pixel();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [12:0] pick_extent();
      case ($urandom_range(0, 19))
         0: return 13'd0;
         1: return 13'd4096;
         2: return 13'h1fff;
         3: return 13'($urandom_range(9, 40));
         default: return 13'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [31:0] pick_value(input fbpb_reg_type index);
      logic [31:0] value;
      int unsigned bits;
      case (index)
         REG_FB_BASE: begin
            bits = 32;
            case ($urandom_range(0, 7))
               0: value = 32'd0;
               1: value = 32'hffff_ffff;
               default: value = $urandom();
            endcase
         end
         REG_ROW_PITCH: begin
            bits = 16;
            case ($urandom_range(0, 5))
               0: value = 32'd0;
               1: value = 32'hffff;
               2: value = $urandom_range(0, 8192);
               default: value = $urandom_range(0, 16'hffff);
            endcase
         end
         REG_X_OFFSET, REG_Y_OFFSET: begin
            bits = 12;
            case ($urandom_range(0, 5))
               0: value = 32'd0;
               1: value = 32'd4095;
               default: value = $urandom_range(0, 4095);
            endcase
         end
         REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
            bits  = 13;
            value = {19'd0, pick_extent()};
         end
         REG_DEPTH_SELECT: begin
            bits  = 2;
            value = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1);
         end
         default: begin
            bits  = 1;
            value = 32'($urandom_range(0, 3) == 0);
         end
      endcase
      if (bits < 32 && $urandom_range(0, 3) == 0) begin
         value = value | ($urandom() << bits);
      end
      return value;
   endfunction

   initial begin : stimulus
      int unsigned sent_total;
      int unsigned count;
      bit          first;
      sent_total = 0;
      first      = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: zero base, so no writes and no frame total.
      repeat (2) push_pixel($urandom());

      // RGB565 with every offset at its top, wrapping addresses; src_is_dst is ignored.
      settle();
      csr_write(REG_FB_BASE, 32'hffff_ffff);
      csr_write(REG_ROW_PITCH, 32'hffff);
      csr_write(REG_X_OFFSET, 32'd4095);
      csr_write(REG_Y_OFFSET, 32'd4095);
      csr_write(REG_FRAME_WIDTH, 32'd2);
      csr_write(REG_FRAME_HEIGHT, 32'd2);
      csr_write(REG_DEPTH_SELECT, 32'(DEPTH_RGB565));
      csr_write(REG_SRC_IS_DST, 32'd1);
      csr_release();
      push_pixel(32'h0000_0000);
      push_pixel(32'hffff_ffff);
      push_pixel(32'h00f8_fcf8);
      push_pixel($urandom());

      // 32-bit copy into itself: no writes, but the frame total is still given.
      settle();
      csr_write(REG_DEPTH_SELECT, 32'(DEPTH_COPY));
      csr_release();
      repeat (4) push_pixel($urandom());

      // Unsupported depths.
      settle();
      csr_write(REG_SRC_IS_DST, 32'd0);
      csr_write(REG_DEPTH_SELECT, 32'd2);
      csr_release();
      repeat (2) push_pixel($urandom());
      settle();
      csr_write(REG_DEPTH_SELECT, 32'd3);
      csr_release();
      push_pixel($urandom());

      // Zero sizes are taken as one.
      settle();
      csr_write(REG_DEPTH_SELECT, 32'(DEPTH_COPY));
      csr_write(REG_FRAME_WIDTH, 32'd0);
      csr_write(REG_FRAME_HEIGHT, 32'd0);
      csr_release();
      repeat (2) push_pixel($urandom());

      // Oversized frame, then shrunk mid-row and mid-frame.
      settle();
      csr_write(REG_FRAME_WIDTH, 32'h1fff);
      csr_write(REG_FRAME_HEIGHT, 32'd4097);
      csr_release();
      repeat (3) push_pixel($urandom());
      settle();
      csr_write(REG_FRAME_WIDTH, 32'd2);
      csr_release();
      repeat (2) push_pixel($urandom());
      settle();
      csr_write(REG_FRAME_HEIGHT, 32'd1);
      csr_release();
      repeat (2) push_pixel($urandom());

      while (sent_total < 1750) begin
         if (sent_total >= 1500) calm <= 1'b1;
         if (first || (sent_total < 1500 && $urandom_range(0, 2) != 0)) begin
            settle();
            for (int i = 0; i < 8; i++) begin
               if (first || $urandom_range(0, 1) == 0) begin
                  csr_write(fbpb_reg_type'(i), pick_value(fbpb_reg_type'(i)));
               end
            end
            csr_release();
            first = 1'b0;
         end else if (sent_total < 1500 && $urandom_range(0, 4) == 0) begin
            settle();
         end
         count = $urandom_range(1, 48);
         repeat (count) push_pixel(pick_pixel());
         sent_total += count;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
